// ----- design/udcrc_pkg.sv -----
// Package for the UART datagram CRC8 engine: item structs, codes, constants
// and the bytewise CRC8 (poly 0x07, LSB-first data) helper. No dependencies.
package udcrc_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] MASTER_ADDR = 8'hFF;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_REPLY = 2'd2
  } op_t;

  typedef enum logic {
    KIND_TX   = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_CRC = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  reg_addr;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [31:0] read_value;
    logic [1:0]  read_status;
  } out_item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int j = 0; j < 8; j++) begin
      mix = c[7] ^ data[j];
      c   = {c[6:0], 1'b0};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/uart_datagram_crc8_engine.sv -----
// Top level of the UART datagram CRC8 engine: request framing, reply checking
// and a one-byte-per-cycle output register unless out_stall holds it. Uses udcrc_pkg.
//
// channel | ports                          | direction | moves
// in      | in_valid, in_stall, in_data    | input     | one request/reply item
// out     | out_valid, out_stall, out_data | output    | one transmit byte or completion
// cfg     | cfg_valid, cfg_ready, cfg_data | input     | node address write
//
// A write item yields 8 transmit bytes, a read item 4, the eighth reply byte one completion;
// other reply bytes are absorbed with no output. One byte leaves per cycle through the
// output register while out_stall is low; the CRC byte is built on the fly as bytes go out.
// The next item is taken in the cycle the frame hands over its last result.
// Reset (rst_n, synchronous) clears the node address, the valid flags and all reply state.
module uart_datagram_crc8_engine
  import udcrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]  node_addr_r;

  logic [2:0]  reply_cnt_r,  reply_cnt_nxt;
  logic [7:0]  reply_crc_r,  reply_crc_nxt;
  logic [6:0]  exp_reg_r,    exp_reg_nxt;
  logic        hdr_err_r,    hdr_err_nxt;
  logic [31:0] val_shift_r,  val_shift_nxt;

  logic        frm_valid_r,  frm_valid_nxt;
  logic        frm_kind_r,   frm_kind_nxt;
  logic [55:0] frm_buf_r,    frm_buf_nxt;
  logic [2:0]  frm_cnt_r,    frm_cnt_nxt;
  logic [7:0]  frm_crc_r,    frm_crc_nxt;
  logic [31:0] frm_value_r,  frm_value_nxt;
  logic [1:0]  frm_status_r, frm_status_nxt;

  logic        out_valid_r,  out_valid_nxt;
  out_item_t   out_r,        out_nxt;

  logic        emit;
  logic        frm_done;
  logic        in_acc;
  logic        frm_load;
  logic [7:0]  cur_byte;
  logic        cur_last;

  assign cfg_ready = 1'b1;
  assign emit      = frm_valid_r && (!out_valid_r || !out_stall);
  assign frm_done  = emit && (frm_cnt_r == 3'd0);
  assign in_stall  = frm_valid_r && !frm_done;
  assign in_acc    = in_valid && !in_stall;
  assign cur_last  = (frm_cnt_r == 3'd0);
  assign cur_byte  = cur_last ? frm_crc_r : frm_buf_r[55:48];

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // item decode and reply collection
  always_comb begin
    reply_cnt_nxt  = reply_cnt_r;
    reply_crc_nxt  = reply_crc_r;
    exp_reg_nxt    = exp_reg_r;
    hdr_err_nxt    = hdr_err_r;
    val_shift_nxt  = val_shift_r;
    frm_load       = 1'b0;
    frm_kind_nxt   = KIND_TX;
    frm_buf_nxt    = '0;
    frm_cnt_nxt    = 3'd0;
    frm_value_nxt  = '0;
    frm_status_nxt = ST_OK;
    if (in_acc) begin
      unique case (in_data.operation)
        OP_WRITE: begin
          frm_load    = 1'b1;
          frm_buf_nxt = {SYNC_BYTE, node_addr_r, 1'b1, in_data.reg_addr, in_data.write_value};
          frm_cnt_nxt = 3'd7;
        end
        OP_READ: begin
          frm_load      = 1'b1;
          frm_buf_nxt   = {SYNC_BYTE, node_addr_r, 1'b0, in_data.reg_addr, 32'h0};
          frm_cnt_nxt   = 3'd3;
          exp_reg_nxt   = in_data.reg_addr;
          reply_cnt_nxt = 3'd0;
          reply_crc_nxt = 8'h00;
          hdr_err_nxt   = 1'b0;
          val_shift_nxt = 32'h0;
        end
        OP_REPLY: begin
          if (reply_cnt_r != 3'd7) begin
            if (reply_cnt_r == 3'd0 && in_data.rx_byte != SYNC_BYTE) begin
              hdr_err_nxt = 1'b1;
            end
            if (reply_cnt_r == 3'd1 && in_data.rx_byte != MASTER_ADDR) begin
              hdr_err_nxt = 1'b1;
            end
            if (reply_cnt_r == 3'd2 && in_data.rx_byte[6:0] != exp_reg_r) begin
              hdr_err_nxt = 1'b1;
            end
            if (reply_cnt_r >= 3'd3) begin
              val_shift_nxt = {val_shift_r[23:0], in_data.rx_byte};
            end
            reply_crc_nxt = crc8_byte(reply_crc_r, in_data.rx_byte);
            reply_cnt_nxt = reply_cnt_r + 3'd1;
          end else begin
            frm_load     = 1'b1;
            frm_kind_nxt = KIND_READ;
            priority if (hdr_err_r) begin
              frm_status_nxt = ST_BAD_HDR;
            end else if (reply_crc_r != in_data.rx_byte) begin
              frm_status_nxt = ST_BAD_CRC;
            end else begin
              frm_status_nxt = ST_OK;
              frm_value_nxt  = val_shift_r;
            end
            reply_cnt_nxt = 3'd0;
            reply_crc_nxt = 8'h00;
            hdr_err_nxt   = 1'b0;
            val_shift_nxt = 32'h0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // frame emitter and output register
  always_comb begin
    frm_valid_nxt = frm_valid_r && !frm_done;
    frm_crc_nxt   = frm_crc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (frm_kind_r == KIND_READ) begin
        out_nxt.result_kind = KIND_READ;
        out_nxt.out_byte    = 8'h00;
        out_nxt.last_byte   = 1'b0;
        out_nxt.read_value  = frm_value_r;
        out_nxt.read_status = frm_status_r;
      end else begin
        out_nxt.result_kind = KIND_TX;
        out_nxt.out_byte    = cur_byte;
        out_nxt.last_byte   = cur_last;
        out_nxt.read_value  = 32'h0;
        out_nxt.read_status = ST_OK;
      end
      frm_crc_nxt = crc8_byte(frm_crc_r, frm_buf_r[55:48]);
    end
    if (frm_load) begin
      frm_valid_nxt = 1'b1;
      frm_crc_nxt   = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 8'h00;
      reply_cnt_r <= 3'd0;
      reply_crc_r <= 8'h00;
      exp_reg_r   <= 7'h00;
      hdr_err_r   <= 1'b0;
      val_shift_r <= 32'h0;
      frm_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_addr_r <= cfg_data;
      end
      reply_cnt_r <= reply_cnt_nxt;
      reply_crc_r <= reply_crc_nxt;
      exp_reg_r   <= exp_reg_nxt;
      hdr_err_r   <= hdr_err_nxt;
      val_shift_r <= val_shift_nxt;
      frm_valid_r <= frm_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_crc_r <= frm_crc_nxt;
    out_r     <= out_nxt;
    if (frm_load) begin
      frm_kind_r   <= frm_kind_nxt;
      frm_buf_r    <= frm_buf_nxt;
      frm_cnt_r    <= frm_cnt_nxt;
      frm_value_r  <= frm_value_nxt;
      frm_status_r <= frm_status_nxt;
    end else if (emit) begin
      frm_buf_r <= {frm_buf_r[47:0], 8'h00};
      frm_cnt_r <= frm_cnt_r - 3'd1;
    end
  end

`ifndef SYNTH
  a_frame_holds: assert property (@(posedge clk) disable iff (!rst_n)
    emit && frm_cnt_r != 3'd0 |=> frm_valid_r)
    else $error("frame dropped before its last byte");

  a_cmpl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.result_kind == KIND_READ |->
      out_r.out_byte == 8'h00 && !out_r.last_byte)
    else $error("completion carries transmit fields");

  a_bad_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.read_status != ST_OK |-> out_r.read_value == 32'h0)
    else $error("failed completion carries a value");
`endif

endmodule

// ----- bench/datagram_checker.sv -----
// Checker for the UART datagram CRC8 engine: watches the in, out and cfg channels,
// predicts transmit bytes and read completions, and counts mismatches. Uses udcrc_pkg.
`timescale 1ns / 1ps
module datagram_checker
  import udcrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [7:0] cfg_data,
  output int        mismatches,
  output int        pending
);

  out_item_t   frame_q[$];
  logic [7:0]  node_addr;
  logic [2:0]  rep_cnt;
  logic [7:0]  rep_crc;
  logic [6:0]  exp_reg;
  logic        hdr_err;
  logic [31:0] val_acc;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[7] ^ b[k]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic report(input out_item_t want, input out_item_t got, input bit stray);
    mismatches++;
    if (mismatches <= 10) begin
      if (stray) begin
        $display("%0t: unexpected item kind=%0d byte=%02h last=%0d value=%08h status=%0d",
                 $realtime, got.result_kind, got.out_byte, got.last_byte, got.read_value,
                 got.read_status);
      end else begin
        $display("%0t: mismatch expected kind=%0d byte=%02h last=%0d value=%08h status=%0d",
                 $realtime, want.result_kind, want.out_byte, want.last_byte, want.read_value,
                 want.read_status);
        $display("%0t:          actual   kind=%0d byte=%02h last=%0d value=%08h status=%0d",
                 $realtime, got.result_kind, got.out_byte, got.last_byte, got.read_value,
                 got.read_status);
      end
    end
  endtask

  task automatic forecast(input in_item_t it);
    logic [7:0] b[8];
    logic [7:0] c;
    int         n;
    out_item_t  r;
    n = 0;
    r = '0;
    case (it.operation)
      OP_WRITE: begin
        b[0] = SYNC_BYTE;
        b[1] = node_addr;
        b[2] = {1'b1, it.reg_addr};
        b[3] = it.write_value[31:24];
        b[4] = it.write_value[23:16];
        b[5] = it.write_value[15:8];
        b[6] = it.write_value[7:0];
        n = 8;
      end
      OP_READ: begin
        b[0] = SYNC_BYTE;
        b[1] = node_addr;
        b[2] = {1'b0, it.reg_addr};
        n = 4;
        exp_reg = it.reg_addr;
        rep_cnt = '0;
        rep_crc = '0;
        hdr_err = 1'b0;
        val_acc = '0;
      end
      OP_REPLY: begin
        if (rep_cnt != 3'd7) begin
          if (rep_cnt == 3'd0 && it.rx_byte != SYNC_BYTE) hdr_err = 1'b1;
          if (rep_cnt == 3'd1 && it.rx_byte != MASTER_ADDR) hdr_err = 1'b1;
          if (rep_cnt == 3'd2 && it.rx_byte[6:0] != exp_reg) hdr_err = 1'b1;
          if (rep_cnt >= 3'd3) val_acc = {val_acc[23:0], it.rx_byte};
          rep_crc = crc8_step(rep_crc, it.rx_byte);
          rep_cnt = rep_cnt + 3'd1;
        end else begin
          r.result_kind = KIND_READ;
          if (hdr_err) begin
            r.read_status = ST_BAD_HDR;
          end else if (rep_crc != it.rx_byte) begin
            r.read_status = ST_BAD_CRC;
          end else begin
            r.read_status = ST_OK;
            r.read_value  = val_acc;
          end
          frame_q.push_back(r);
          rep_cnt = '0;
          rep_crc = '0;
          hdr_err = 1'b0;
          val_acc = '0;
        end
      end
      default: n = 0;
    endcase
    if (n > 0) begin
      c = '0;
      for (int i = 0; i < n - 1; i++) c = crc8_step(c, b[i]);
      b[n-1] = c;
      for (int i = 0; i < n; i++) begin
        r = '0;
        r.result_kind = KIND_TX;
        r.out_byte    = b[i];
        r.last_byte   = (i == n - 1);
        frame_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      frame_q.delete();
      node_addr = '0;
      rep_cnt   = '0;
      rep_crc   = '0;
      exp_reg   = '0;
      hdr_err   = 1'b0;
      val_acc   = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          report('0, out_data, 1'b1);
        end else begin
          want = frame_q.pop_front();
          if (out_data.result_kind !== want.result_kind || out_data.out_byte !== want.out_byte ||
              out_data.last_byte !== want.last_byte || out_data.read_value !== want.read_value ||
              out_data.read_status !== want.read_status) begin
            report(want, out_data, 1'b0);
          end
        end
      end
      if (cfg_valid && cfg_ready) node_addr = cfg_data;
      if (in_valid && !in_stall) forecast(in_data);
    end
    pending <= frame_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Testbench top for the UART datagram CRC8 engine: reset, node address phases,
// directed and random request/reply items, output stalls and the verdict.
// Depends on udcrc_pkg, uart_datagram_crc8_engine and datagram_checker.
`timescale 1ns / 1ps
module testbench;
  import udcrc_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int HDR_NONE = 0;
  localparam int HDR_SYNC = 1;
  localparam int HDR_ADDR = 2;
  localparam int HDR_REG  = 3;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 310;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;
  int         mismatches;
  int         pending;
  bit         calm = 1'b0;
  int         sent = 0;
  int         stall_run = 0;
  logic [6:0] last_read = '0;

  uart_datagram_crc8_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  datagram_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int gap_len();
    int x;
    x = $urandom_range(0, 99);
    if (calm || x < 55) return 0;
    if (x < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_run == 0 && !calm && $urandom_range(0, 3) == 0) begin
      stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [1:0] op, input logic [6:0] reg_addr,
                      input logic [31:0] value, input logic [7:0] rx);
    in_item_t it;
    int       g;
    it.operation   = op;
    it.reg_addr    = reg_addr;
    it.write_value = value;
    it.rx_byte     = rx;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (op != OP_NOP) sent++;
  endtask

  task automatic send_write(input logic [6:0] reg_addr, input logic [31:0] value);
    send(OP_WRITE, reg_addr, value, 8'($urandom));
  endtask

  task automatic send_random_write();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    send_write(7'($urandom), v);
  endtask

  task automatic send_read(input logic [6:0] reg_addr);
    last_read = reg_addr;
    send(OP_READ, reg_addr, $urandom, 8'($urandom));
  endtask

  // reply frame: sync, master address, register, value MSB first, CRC;
  // optional header or CRC corruption, truncation and a write slipped in
  task automatic send_reply(input logic [6:0] reg_addr, input logic [31:0] value,
                            input int hdr_fault, input bit crc_fault,
                            input int nbytes, input int wr_at);
    logic [7:0] b[8];
    logic [7:0] c;
    b[0] = SYNC_BYTE;
    b[1] = MASTER_ADDR;
    b[2] = {1'($urandom), reg_addr};
    b[3] = value[31:24];
    b[4] = value[23:16];
    b[5] = value[15:8];
    b[6] = value[7:0];
    case (hdr_fault)
      HDR_SYNC: b[0] ^= 8'($urandom_range(1, 255));
      HDR_ADDR: b[1] ^= 8'($urandom_range(1, 255));
      HDR_REG:  b[2] ^= {1'b0, 7'($urandom_range(1, 127))};
      default: ;
    endcase
    c = '0;
    for (int i = 0; i < 7; i++) begin
      for (int k = 0; k < 8; k++) begin
        c = (c[7] ^ b[i][k]) ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
    end
    b[7] = crc_fault ? (c ^ 8'($urandom_range(1, 255))) : c;
    for (int i = 0; i < nbytes; i++) begin
      if (i == wr_at) send_random_write();
      send(OP_REPLY, 7'($urandom), $urandom, b[i]);
    end
  endtask

  task automatic release_in();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_node(input logic [7:0] addr);
    release_in();
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic random_burst();
    int r;
    int hdr;
    r    = $urandom_range(0, 99);
    calm = ($urandom_range(0, 9) == 0);
    if (r < 15) begin
      send_random_write();
    end else if (r < 75) begin
      send_read(7'($urandom));
      hdr = ($urandom_range(0, 9) < 6) ? HDR_NONE : $urandom_range(HDR_SYNC, HDR_REG);
      send_reply(last_read, $urandom, hdr, $urandom_range(0, 3) == 0,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 8,
                 ($urandom_range(0, 19) < 2) ? $urandom_range(0, 7) : -1);
    end else if (r < 85) begin
      repeat ($urandom_range(1, 8)) send(OP_REPLY, 7'($urandom), $urandom, 8'($urandom));
    end else if (r < 92) begin
      send_reply(last_read, $urandom, HDR_NONE, 1'b0, 8, -1);
    end else begin
      send(OP_NOP, 7'($urandom), $urandom, 8'($urandom));
    end
  endtask

  initial begin
    int target;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reply with no read before it, checked against register 0
    send_reply(7'd0, 32'h1234_5678, HDR_NONE, 1'b0, 8, -1);
    send(OP_NOP, 7'h7F, '1, 8'hFF);
    send_write(7'd0, 32'h0000_0000);
    send_write(7'h7F, 32'hFFFF_FFFF);
    set_node(8'hFF);
    send_read(7'h55);
    send_reply(7'h55, 32'hDEAD_BEEF, HDR_NONE, 1'b0, 3, -1);
    send_read(7'h2A);
    // header and CRC both wrong, with a write in the middle of the reply
    send_reply(7'h2A, 32'hA5A5_5A5A, HDR_ADDR, 1'b1, 8, 4);

    for (int p = 0; p < 4; p++) begin
      if (p == 1) set_node(8'h00);
      if (p > 1) set_node(8'($urandom));
      target = RANDOM_ITEMS * (p + 1) / 4;
      while (sent < target) random_burst();
    end
    calm = 1'b0;

    release_in();
    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
